// ----- rtl/md5_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, chaining constants and round tables for the MD5 hasher.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       final_item;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_hi;
        logic [63:0] digest_lo;
    } t_out_item;

    // Working / chaining words of the compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_abcd;

    // How the message block is presented to the round unit
    typedef struct packed {
        logic [6:0] cut;      // bytes below this index come from the buffer
        logic       put80;    // place the 0x80 pad byte at index cut
        logic       put_len;  // bytes 56..63 carry the bit length
    } t_pad_ctl;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LEN_POS    = 6'd56;

    localparam t_abcd C_CHAIN_INIT = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    // Additive round constant
    function automatic logic [31:0] md5_k(input logic [5:0] rnd);
        logic [31:0] k;
        case (rnd)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Left-rotate amount, indexed by quarter and round mod 4
    function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by a round
    function automatic logic [3:0] md5_widx(input logic [5:0] rnd);
        logic [3:0] r;
        logic [3:0] w;
        r = rnd[3:0];
        case (rnd[5:4])
            2'd0:    w = r;
            2'd1:    w = 4'((r << 2) + r + 4'd1);
            2'd2:    w = 4'((r << 1) + r + 4'd5);
            default: w = 4'((r << 3) - r);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/md5_blkbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_blkbuf
// 64-byte message block store with on-the-fly pad and length insertion.
// ----------------------------------------------------------------------------
module md5_blkbuf (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [5:0]          i_wr_pos,
    input  logic [7:0]          i_wr_data,
    input  logic [3:0]          i_rd_idx,
    input  md5_pkg::t_pad_ctl   i_pad,
    input  logic [63:0]         i_len,
    output logic [31:0]         o_word
);
    import md5_pkg::*;

    logic [31:0] mem [16];
    logic [31:0] raw_word;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_pos[5:2]][8*i_wr_pos[1:0] +: 8] <= i_wr_data;
        end
    end

    assign raw_word = mem[i_rd_idx];

    // Bytes at or past the fill point are pad, zero or length; never stale data.
    always_comb begin
        logic [5:0] bpos;
        o_word = '0;
        for (int j = 0; j < 4; j++) begin
            bpos = {i_rd_idx, 2'(j)};
            if ({1'b0, bpos} < i_pad.cut) begin
                o_word[8*j +: 8] = raw_word[8*j +: 8];
            end else if (i_pad.put80 && (bpos == i_pad.cut[5:0])) begin
                o_word[8*j +: 8] = PAD_BYTE;
            end else if (i_pad.put_len && (bpos >= LEN_POS)) begin
                o_word[8*j +: 8] = i_len[8*bpos[2:0] +: 8];
            end
        end
    end

endmodule

// ----- rtl/md5_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_round
// One MD5 round step; shared across all 64 rounds of a compression.
// ----------------------------------------------------------------------------
module md5_round (
    input  logic [5:0]       i_rnd,
    input  md5_pkg::t_abcd   i_st,
    input  logic [31:0]      i_wk,     // message word plus round constant
    output md5_pkg::t_abcd   o_st
);
    import md5_pkg::*;

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot2;
    logic [4:0]  sh;

    always_comb begin
        case (i_rnd[5:4])
            2'd0:    f = (i_st.b & i_st.c) | (~i_st.b & i_st.d);
            2'd1:    f = (i_st.d & i_st.b) | (~i_st.d & i_st.c);
            2'd2:    f = i_st.b ^ i_st.c ^ i_st.d;
            default: f = i_st.c ^ (i_st.b | ~i_st.d);
        endcase
    end

    assign sum  = f + i_st.a + i_wk;
    assign sh   = md5_rot(i_rnd);
    assign rot2 = {sum, sum} << sh;

    assign o_st.a = i_st.d;
    assign o_st.b = i_st.b + rot2[63:32];
    assign o_st.c = i_st.b;
    assign o_st.d = i_st.c;

endmodule

// ----- rtl/md5_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher
// Streaming MD5 digest engine, one message byte per input transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries at most one message byte and an end flag;
// an end transaction with no byte is legal, so the empty message works. A
// byte that does not complete a 64-byte block is absorbed in the accept
// cycle and the input is ready again on the next clock. A byte that
// completes a block, and every end transaction, starts a compression on the
// single round unit: a load step, the 64 rounds (one round per clock)
// and a chaining update, and the input stalls for the whole compression.
// An end transaction needs one compression, or two when the padded length
// spills past byte 55, plus one more if its own byte closed a block, and
// then an emit step moves the digest into the output register. The digest
// waits there (digest_lo holds bytes 0..7, byte 0 in bits 7:0) while the
// next message is already being taken; only a second digest that finds the
// output register still full holds the engine. After the digest the chain
// returns to the MD5 initial values and the bit count to zero; the bit
// count wraps modulo 2^64.
// ----------------------------------------------------------------------------
module md5_stream_hasher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // message input
    input  logic                 i_in_valid,
    input  md5_pkg::t_in_item    i_in_item,
    output logic                 o_in_stall,
    // digest output
    output logic                 o_out_valid,
    output md5_pkg::t_out_item   o_out_item,
    input  logic                 i_out_stall
);
    import md5_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // taking bytes
    localparam logic [2:0] S_PREP = 3'd1;  // load working words, prefetch round 0
    localparam logic [2:0] S_RUN  = 3'd2;  // one round per cycle
    localparam logic [2:0] S_FIN  = 3'd3;  // fold working words into chain
    localparam logic [2:0] S_EMIT = 3'd4;  // hand digest to output register

    logic [2:0]   r_state, n_state;
    t_abcd        r_chain, n_chain;
    logic [63:0]  r_bit_count, n_bit_count;
    logic         r_pend_final, n_pend_final;
    logic         r_out_valid, n_out_valid;
    t_out_item    r_out_item, n_out_item;
    t_abcd        r_work, n_work;
    logic [31:0]  r_wk, n_wk;
    logic [5:0]   r_rnd, n_rnd;
    t_pad_ctl     r_pad, n_pad;

    logic         in_acc;
    logic         out_free;
    logic [5:0]   pos;
    logic [5:0]   pos_nx;
    logic [5:0]   rd_rnd;
    logic [31:0]  buf_word;
    t_abcd        round_st;
    logic         wr_en;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign out_free    = !r_out_valid || !i_out_stall;

    // fill position comes straight from the byte count
    assign pos    = r_bit_count[8:3];
    assign pos_nx = pos + 6'(i_in_item.byte_present);
    assign wr_en  = in_acc && i_in_item.byte_present;

    // word + constant are fetched one round ahead of use
    assign rd_rnd = (r_state == S_PREP) ? 6'd0 : r_rnd + 6'd1;

    md5_blkbuf u_blkbuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_pos  (pos),
        .i_wr_data (i_in_item.data_byte),
        .i_rd_idx  (md5_widx(rd_rnd)),
        .i_pad     (r_pad),
        .i_len     (r_bit_count),
        .o_word    (buf_word)
    );

    md5_round u_round (
        .i_rnd (r_rnd),
        .i_st  (r_work),
        .i_wk  (r_wk),
        .o_st  (round_st)
    );

    always_comb begin
        n_state      = r_state;
        n_chain      = r_chain;
        n_bit_count  = r_bit_count;
        n_pend_final = r_pend_final;
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_work       = r_work;
        n_wk         = r_wk;
        n_rnd        = r_rnd;
        n_pad        = r_pad;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.byte_present) begin
                        n_bit_count = r_bit_count + 64'd8;
                    end
                    if (i_in_item.byte_present && (pos_nx == 6'd0)) begin
                        // block full: compress the plain message block
                        n_pad        = '{cut: 7'd64, put80: 1'b0, put_len: 1'b0};
                        n_pend_final = i_in_item.final_item;
                        n_state      = S_PREP;
                    end else if (i_in_item.final_item) begin
                        // length fits after the pad byte only below byte 56
                        n_pad        = '{cut: {1'b0, pos_nx}, put80: 1'b1,
                                         put_len: (pos_nx < LEN_POS)};
                        n_pend_final = 1'b0;
                        n_state      = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_work  = r_chain;
                n_wk    = buf_word + md5_k(rd_rnd);
                n_rnd   = '0;
                n_state = S_RUN;
            end
            S_RUN: begin
                n_work = round_st;
                n_wk   = buf_word + md5_k(rd_rnd);
                n_rnd  = r_rnd + 6'd1;
                if (r_rnd == 6'(NUM_ROUNDS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_chain.a = r_chain.a + r_work.a;
                n_chain.b = r_chain.b + r_work.b;
                n_chain.c = r_chain.c + r_work.c;
                n_chain.d = r_chain.d + r_work.d;
                if (r_pad.put_len) begin
                    n_state = S_EMIT;
                end else if (r_pad.put80) begin
                    // pad byte went out last block; this one is zeros + length
                    n_pad   = '{cut: 7'd0, put80: 1'b0, put_len: 1'b1};
                    n_state = S_PREP;
                end else if (r_pend_final) begin
                    // end flag rode on the byte that closed the block
                    n_pad        = '{cut: 7'd0, put80: 1'b1, put_len: 1'b1};
                    n_pend_final = 1'b0;
                    n_state      = S_PREP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_item.digest_lo = {r_chain.b, r_chain.a};
                    n_out_item.digest_hi = {r_chain.d, r_chain.c};
                    n_chain              = C_CHAIN_INIT;
                    n_bit_count          = '0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chain      <= C_CHAIN_INIT;
            r_bit_count  <= '0;
            r_pend_final <= 1'b0;
            r_out_valid  <= 1'b0;
            r_rnd        <= '0;
        end else begin
            r_state      <= n_state;
            r_chain      <= n_chain;
            r_bit_count  <= n_bit_count;
            r_pend_final <= n_pend_final;
            r_out_valid  <= n_out_valid;
            r_rnd        <= n_rnd;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_work     <= n_work;
        r_wk       <= n_wk;
        r_pad      <= n_pad;
    end

endmodule

// ----- verif/md5_stream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_checker
// Watches both channels of the MD5 hasher, predicts digests and compares.
// ----------------------------------------------------------------------------
// Every accepted input transaction is folded into a private MD5 state. An
// end transaction adds a predicted digest to a queue. Each accepted output
// transaction is checked against the oldest predicted digest.
// ----------------------------------------------------------------------------
module md5_stream_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  md5_pkg::t_in_item    i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  md5_pkg::t_out_item   i_out_item,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked
);
    import md5_pkg::*;

    // Additive constants, round 0 in the top word
    localparam logic [64*32-1:0] ROUND_ADD = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts by quarter and round mod 4, entry 0 on top
    localparam logic [16*5-1:0] ROUND_SHIFT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    logic [31:0] chain_q [4];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;
    t_out_item   digest_q [$];

    task automatic restart_chain();
        chain_q[0] = C_CHAIN_INIT.a;
        chain_q[1] = C_CHAIN_INIT.b;
        chain_q[2] = C_CHAIN_INIT.c;
        chain_q[3] = C_CHAIN_INIT.d;
        msg_bits   = '0;
    endtask

    task automatic md5_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int          k;
        int          sh;
        for (int r = 0; r < 16; r++)
            w[r] = {msg_block[4*r+3], msg_block[4*r+2], msg_block[4*r+1], msg_block[4*r]};
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                f = (b & c) | (~b & d);
                k = r;
            end else if (r < 32) begin
                f = (d & b) | (~d & c);
                k = (5 * r + 1) % 16;
            end else if (r < 48) begin
                f = b ^ c ^ d;
                k = (3 * r + 5) % 16;
            end else begin
                f = c ^ (b | ~d);
                k = (7 * r) % 16;
            end
            sh = int'(ROUND_SHIFT[(15 - ((r / 16) * 4 + r % 4)) * 5 +: 5]);
            t  = f + a + ROUND_ADD[(63 - r) * 32 +: 32] + w[k];
            a  = d;
            d  = c;
            c  = b;
            b  = b + ((t << sh) | (t >> (32 - sh)));
        end
        chain_q[0] = chain_q[0] + a;
        chain_q[1] = chain_q[1] + b;
        chain_q[2] = chain_q[2] + c;
        chain_q[3] = chain_q[3] + d;
    endtask

    // Fold one input transaction into the running hash
    task automatic md5_absorb(input t_in_item item);
        int          pos;
        logic [63:0] len;
        t_out_item   dg;
        pos = int'(msg_bits[8:3]);
        if (item.byte_present) begin
            msg_block[pos] = item.data_byte;
            msg_bits       = msg_bits + 64'd8;
            pos            = (pos + 1) % 64;
            if (pos == 0)
                md5_compress();
        end
        if (item.final_item) begin
            len            = msg_bits;
            msg_block[pos] = PAD_BYTE;
            pos            = pos + 1;
            if (pos > int'(LEN_POS)) begin
                while (pos < 64) begin
                    msg_block[pos] = 8'h00;
                    pos            = pos + 1;
                end
                md5_compress();
                pos = 0;
            end
            while (pos < int'(LEN_POS)) begin
                msg_block[pos] = 8'h00;
                pos            = pos + 1;
            end
            for (int i = 0; i < 8; i++)
                msg_block[int'(LEN_POS) + i] = len[8*i +: 8];
            md5_compress();
            dg.digest_lo = {chain_q[1], chain_q[0]};
            dg.digest_hi = {chain_q[3], chain_q[2]};
            digest_q.push_back(dg);
            restart_chain();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            restart_chain();
            digest_q.delete();
            o_errors  <= 0;
            o_checked <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                md5_absorb(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest %h_%h", $time,
                             i_out_item.digest_hi, i_out_item.digest_lo);
                    o_errors <= o_errors + 1;
                end else begin
                    want = digest_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_out_item.digest_lo !== want.digest_lo) begin
                        $display("%0t: digest_lo expected %h actual %h", $time,
                                 want.digest_lo, i_out_item.digest_lo);
                        o_errors <= o_errors + 1;
                    end else if (i_out_item.digest_hi !== want.digest_hi) begin
                        $display("%0t: digest_hi expected %h actual %h", $time,
                                 want.digest_hi, i_out_item.digest_hi);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= digest_q.size();
    end

endmodule

// ----- verif/md5_stream_hasher_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher_test
// Stimulus and verdict for the streaming MD5 hasher.
// ----------------------------------------------------------------------------
// Drives byte streams of mixed lengths, clustered around the padding spill
// point and block boundaries, with random send gaps and output stalls. The
// checker beside the block predicts every digest and counts mismatches.
// ----------------------------------------------------------------------------
module md5_stream_hasher_test;
    import md5_pkg::*;

    localparam int ITEM_TARGET = 1750;  // message transactions in the random part
    localparam int TAIL_START  = 1580;  // no idling from here on
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE      = 250;   // up to two compressions per end transaction

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;
    logic       out_stall = 1'b0;

    int         errors;
    int         pending;
    int         checked;

    // Stimulus bookkeeping
    int         items_sent  = 0;  // transactions carrying a byte or an end flag
    int         noise_sent  = 0;  // transactions with neither flag
    int         msgs_sent   = 0;
    bit         idle_on     = 1'b1;
    bit         gappy       = 1'b0;

    md5_stream_hasher u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    md5_stream_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("timeout: %0d digests still pending", pending);
        $display("[md5_stream_hasher] ERROR");
        $finish;
    end

    // Receiver: stall bursts of random length, with occasional long quiet
    // stretches. Stalls stop once idle_on drops for the tail of the run.
    initial begin
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_stall <= 1'b0;
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(20, 150)) @(negedge clk);
            end
        end
    end

    // One input transaction. Called at a falling edge, returns at the
    // falling edge after acceptance with valid still high, so back-to-back
    // transactions never lower and raise valid in the same step.
    task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
        if (idle_on && gappy && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_item  <= '{data_byte: data, byte_present: present, final_item: fin};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (present || fin)
            items_sent++;
        else
            noise_sent++;
        @(negedge clk);
    endtask

    // Random message of n bytes; the last byte either rides on the end
    // transaction or the end comes alone. Stray no-op transactions sneak in.
    task automatic send_message(input int n_bytes, input bit byte_on_end);
        int plain;
        plain = (byte_on_end && n_bytes > 0) ? n_bytes - 1 : n_bytes;
        gappy = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < plain; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, 1'b0);
        end
        if (plain < n_bytes)
            send_item(8'($urandom), 1'b1, 1'b1);
        else
            send_item(8'($urandom), 1'b0, 1'b1);
        msgs_sent++;
    endtask

    // Lengths lean toward the spill at 56 bytes and the block edges
    function automatic int pick_length();
        int n;
        case ($urandom_range(0, 11))
            0:          n = 0;
            1, 2, 3, 4: n = $urandom_range(1, 12);
            5:          n = $urandom_range(53, 66);
            6:          n = $urandom_range(13, 52);
            7:          n = $urandom_range(117, 130);
            8:          n = 64 * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
            9:          n = $urandom_range(131, 200);
            default:    n = $urandom_range(1, 64);
        endcase
        return n;
    endfunction

    initial begin
        int waited;
        int fails;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        gappy = 1'b0;
        // Empty message: end transaction with no byte
        send_item(8'h00, 1'b0, 1'b1);
        // "abc", last byte on the end transaction, no-op transactions between
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // Sender holds off until both digests are out
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        // Single byte 0x00 with end
        send_item(8'h00, 1'b1, 1'b1);
        // Extreme bytes then a bare end
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        // Back-to-back empty messages
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        // Byte plus end on the byte that lands at the spill position
        send_message(56, 1'b1);
        msgs_sent = msgs_sent + 6;

        // ---- random part ----
        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= TAIL_START)
                idle_on = 1'b0;
            send_message(pick_length(), bit'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;

        // ---- drain ----
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);

        fails = errors;
        if (pending != 0) begin
            $display("%0t: %0d expected digests never arrived", $time, pending);
            fails++;
        end
        $display("%0d messages, %0d random byte/end transactions plus %0d no-ops,",
                 msgs_sent, items_sent, noise_sent);
        $display("%0d digests compared, lengths up to 200 bytes across block edges",
                 checked);
        if (fails == 0)
            $display("[md5_stream_hasher] OK");
        else
            $display("[md5_stream_hasher] ERROR");
        $finish;
    end

endmodule
